// ----- rtl/core/deq_pkg.sv -----
// Package for the double-ended queue: request, response and internal task
// types, command, operation and status codes. It depends on nothing else.
package deq_pkg;

   localparam logic [3:0] CMD_PUSH_BACK  = 4'd0;
   localparam logic [3:0] CMD_PUSH_FRONT = 4'd1;
   localparam logic [3:0] CMD_POP_BACK   = 4'd2;
   localparam logic [3:0] CMD_POP_FRONT  = 4'd3;
   localparam logic [3:0] CMD_READ_INDEX = 4'd4;
   localparam logic [3:0] CMD_FIRST      = 4'd5;
   localparam logic [3:0] CMD_LAST       = 4'd6;
   localparam logic [3:0] CMD_FIND       = 4'd7;
   localparam logic [3:0] CMD_REVERSE    = 4'd8;
   localparam logic [3:0] CMD_CLEAR      = 4'd9;

   localparam logic [2:0] OP_NOP     = 3'd0;
   localparam logic [2:0] OP_PUSH    = 3'd1;
   localparam logic [2:0] OP_POP     = 3'd2;
   localparam logic [2:0] OP_READ    = 3'd3;
   localparam logic [2:0] OP_FIND    = 3'd4;
   localparam logic [2:0] OP_REVERSE = 3'd5;
   localparam logic [2:0] OP_CLEAR   = 3'd6;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_EMPTY     = 3'd1;
   localparam logic [2:0] STAT_RANGE     = 3'd2;
   localparam logic [2:0] STAT_FULL      = 3'd3;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

   typedef struct packed {
      logic [3:0]  command;
      logic [31:0] value;
      logic [3:0]  position;
   } deq_req_type;

   typedef struct packed {
      logic [31:0] result_data;
      logic [3:0]  found_position;
      logic [2:0]  status;
      logic [4:0]  occupancy;
   } deq_rsp_type;

   // A decoded request as it waits between the front and the back end.
   // sel_last picks the logical back end for push, pop and first/last reads.
   typedef struct packed {
      logic [2:0]  op;
      logic        sel_last;
      logic        by_pos;
      logic [31:0] value;
      logic [3:0]  position;
   } deq_task_type;

   // Handshake between the decode queue and the execution unit.
   typedef struct packed {
      logic         valid;
      deq_task_type work;
   } deq_issue_type;

endpackage

// ----- rtl/core/deq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the entry store of the double-ended queue.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/deq_front.sv -----
// Front end of the double-ended queue: takes requests, decodes each command
// into an operation and holds it in a two-entry queue. Uses deq_pkg.
module deq_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  deq_pkg::deq_req_type req_data,
   output deq_pkg::deq_issue_type issue,
   input  logic                 issue_take
);

   deq_pkg::deq_task_type q_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            fill_ff, fill_in;
   deq_pkg::deq_task_type decoded;
   logic                  push;
   logic                  pop;

   always_comb begin
      decoded.op       = deq_pkg::OP_NOP;
      decoded.sel_last = 1'b0;
      decoded.by_pos   = 1'b0;
      decoded.value    = req_data.value;
      decoded.position = req_data.position;
      unique case (req_data.command) inside
         deq_pkg::CMD_PUSH_BACK: begin
            decoded.op       = deq_pkg::OP_PUSH;
            decoded.sel_last = 1'b1;
         end
         deq_pkg::CMD_PUSH_FRONT: begin
            decoded.op = deq_pkg::OP_PUSH;
         end
         deq_pkg::CMD_POP_BACK: begin
            decoded.op       = deq_pkg::OP_POP;
            decoded.sel_last = 1'b1;
         end
         deq_pkg::CMD_POP_FRONT: begin
            decoded.op = deq_pkg::OP_POP;
         end
         deq_pkg::CMD_READ_INDEX: begin
            decoded.op     = deq_pkg::OP_READ;
            decoded.by_pos = 1'b1;
         end
         deq_pkg::CMD_FIRST: begin
            decoded.op = deq_pkg::OP_READ;
         end
         deq_pkg::CMD_LAST: begin
            decoded.op       = deq_pkg::OP_READ;
            decoded.sel_last = 1'b1;
         end
         deq_pkg::CMD_FIND: begin
            decoded.op = deq_pkg::OP_FIND;
         end
         deq_pkg::CMD_REVERSE: begin
            decoded.op = deq_pkg::OP_REVERSE;
         end
         deq_pkg::CMD_CLEAR: begin
            decoded.op = deq_pkg::OP_CLEAR;
         end
         default: begin
            decoded.op = deq_pkg::OP_NOP;
         end
      endcase
   end

   assign req_ready   = (fill_ff != 2'd2);
   assign push        = req_valid && req_ready;
   assign issue.valid = (fill_ff != 2'd0);
   assign issue.work  = q_ff[rd_ptr_ff];
   assign pop         = issue.valid && issue_take;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ----- rtl/core/deq_back.sv -----
// Back end of the double-ended queue: carries out decoded operations on the
// ring store and drives the response register. Uses deq_pkg and deq_ram.
module deq_back #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  deq_pkg::deq_issue_type issue,
   output logic                   issue_take,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output deq_pkg::deq_rsp_type   rsp_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (CNT_W > 4) ? CNT_W : 4;
   localparam logic [PTR_W:0]   DEPTH_S = (PTR_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_FIND = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [PTR_W-1:0]      front_ff, front_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rev_ff, rev_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   deq_pkg::deq_rsp_type  rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;
   logic                  rd_en;
   logic [PTR_W-1:0]      rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [63:0]           rd_wide;

   logic                  out_free;
   logic                  emit;
   logic [31:0]           emit_data;
   logic [3:0]            emit_found;
   logic [2:0]            emit_status;
   logic                  at_low;
   deq_pkg::deq_task_type work;

   // Physical slot of a logical index; the index is at most the count.
   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] fp,
                                                 input logic [CNT_W-1:0] cnt,
                                                 input logic             rv,
                                                 input logic [CNT_W-1:0] li);
      logic [CNT_W-1:0] off;
      logic [PTR_W:0]   sum;
      begin
         off = rv ? (cnt - CNT_W'(1) - li) : li;
         sum = {1'b0, fp} + (PTR_W + 1)'(off);
         if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
         end
         slot_of = sum[PTR_W-1:0];
      end
   endfunction

   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (DATA_WIDTH'(work.value)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign work     = issue.work;
   assign rd_wide  = 64'(rd_data);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign at_low   = (!work.sel_last) ^ rev_ff;

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      rev_in       = rev_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      issue_take   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = front_ff;
      rd_en        = 1'b0;
      rd_addr      = front_ff;
      emit         = 1'b0;
      emit_data    = 32'd0;
      emit_found   = 4'd0;
      emit_status  = deq_pkg::STAT_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (issue.valid && out_free) begin
               issue_take = 1'b1;
               unique case (work.op)
                  deq_pkg::OP_PUSH: begin
                     emit = 1'b1;
                     if (count_ff == DEPTH_C) begin
                        emit_status = deq_pkg::STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        if (at_low) begin
                           front_in = (front_ff == '0) ? LAST_SLOT
                                                       : front_ff - PTR_W'(1);
                           wr_addr  = front_in;
                        end else begin
                           wr_addr = slot_of(front_ff, count_ff, 1'b0, count_ff);
                        end
                     end
                  end
                  deq_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        emit        = 1'b1;
                        emit_status = deq_pkg::STAT_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = slot_of(front_ff, count_ff, rev_ff,
                                           work.sel_last ? count_ff - CNT_W'(1) : '0);
                        count_in = count_ff - CNT_W'(1);
                        if (at_low) begin
                           front_in = (front_ff == LAST_SLOT) ? '0
                                                              : front_ff + PTR_W'(1);
                        end
                        state_in = ST_READ;
                     end
                  end
                  deq_pkg::OP_READ: begin
                     if (work.by_pos) begin
                        if (IDX_W'(work.position) >= IDX_W'(count_ff)) begin
                           emit        = 1'b1;
                           emit_status = deq_pkg::STAT_RANGE;
                        end else begin
                           rd_en    = 1'b1;
                           rd_addr  = slot_of(front_ff, count_ff, rev_ff,
                                              CNT_W'(work.position));
                           state_in = ST_READ;
                        end
                     end else if (count_ff == '0) begin
                        emit        = 1'b1;
                        emit_status = deq_pkg::STAT_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = slot_of(front_ff, count_ff, rev_ff,
                                           work.sel_last ? count_ff - CNT_W'(1) : '0);
                        state_in = ST_READ;
                     end
                  end
                  deq_pkg::OP_FIND: begin
                     key_in = DATA_WIDTH'(work.value);
                     idx_in = '0;
                     if (count_ff == '0) begin
                        emit        = 1'b1;
                        emit_status = deq_pkg::STAT_NOT_FOUND;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = slot_of(front_ff, count_ff, rev_ff, '0);
                        state_in = ST_FIND;
                     end
                  end
                  deq_pkg::OP_REVERSE: begin
                     emit   = 1'b1;
                     rev_in = !rev_ff;
                  end
                  deq_pkg::OP_CLEAR: begin
                     emit     = 1'b1;
                     front_in = '0;
                     count_in = '0;
                     rev_in   = 1'b0;
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            emit      = 1'b1;
            emit_data = rd_wide[31:0];
            state_in  = ST_IDLE;
         end
         ST_FIND: begin
            // Compares the word read last cycle while fetching the next one.
            if (rd_data == key_ff) begin
               emit       = 1'b1;
               emit_found = 4'(idx_ff);
               state_in   = ST_IDLE;
            end else if (idx_ff + CNT_W'(1) == count_ff) begin
               emit        = 1'b1;
               emit_status = deq_pkg::STAT_NOT_FOUND;
               state_in    = ST_IDLE;
            end else begin
               idx_in  = idx_ff + CNT_W'(1);
               rd_en   = 1'b1;
               rd_addr = slot_of(front_ff, count_ff, rev_ff, idx_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.result_data    = emit_data;
         rsp_in.found_position = emit_found;
         rsp_in.status         = emit_status;
         rsp_in.occupancy      = 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/double_ended_queue_core.sv -----
// Double-ended queue of DEPTH words of DATA_WIDTH bits held in a ring RAM.
// Each request gives exactly one response. Requests are decoded into a
// two-entry queue, so a new request is taken while the previous one runs or
// its response waits. The execution unit handles one request at a time:
// push, reverse, clear, unused codes and every refused request are answered
// from the idle state; pop, indexed read, first and last wait in a read
// state for the registered RAM read; find compares the entries in turn, up
// to the number held, as it walks the ring one RAM read per cycle.
// After reset the queue is empty; no clearing pass is needed.
// Depends on deq_pkg, deq_front, deq_back and deq_ram.
module double_ended_queue_core #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  deq_pkg::deq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output deq_pkg::deq_rsp_type rsp_data
);

   deq_pkg::deq_issue_type issue;
   logic                   issue_take;

   deq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .issue      (issue),
      .issue_take (issue_take)
   );

   deq_back #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .issue_take (issue_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
